// ===== sv/bsar_pkg.sv =====
// Shared codes, widths and the result word for the deadlock-avoidance block.
// No dependencies; every other file imports this package.
`default_nettype none

package bsar_pkg;

  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 4;
  localparam int AMT_W  = 8;
  localparam int SEQ_W  = 4;
  localparam int CFG_W  = 5;

  localparam logic [CMD_W-1:0] CMD_WR_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_MAX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_AVAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REQUEST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd4;

  localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_SAFE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNSAFE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXCEEDS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNAVAIL  = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_PROC = 3'd5;

  localparam logic CFG_NUM_PROC = 1'b0;
  localparam logic CFG_NUM_RES  = 1'b1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/bsar_out_reg.sv =====
// Output register for result words with a valid/ready handshake.
// Depends on bsar_pkg for the result word type.
`default_nettype none

module bsar_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bsar_pkg::out_word_t word,
  output logic                valid,
  input  logic                ready,
  output bsar_pkg::out_word_t word_q
);
  import bsar_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_q <= word;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bankers_safety_and_request_top.sv =====
// Deadlock-avoidance engine: allocation/maximum tables, request check and safety scan.
// Depends on bsar_pkg and bsar_out_reg.
`default_nettype none

// A table or available write, a non-final request element or a refused bad process
// answers with one word, loaded into the output register when it is accepted. A final
// request element walks the m resources in use once to check need and availability,
// once to grant and once to load the work vector; the safety scan then takes up to n
// passes over n processes. Each process index visited is one step, each unfinished
// process is tested by a walk over its resources, and each process that can finish
// releases its allocation into the work vector by another walk. A safe result streams
// n words, each read from the order memory and then loaded into the output register;
// an unsafe one after a request first rolls the grant back over the m resources.
// All tables sit in synchronous memories with one read port, so each step of a walk
// is one memory read and the safety scan dominates the time taken.
// The next word is taken only after the current one ends.
module bankers_safety_and_request_top #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int COUNT_WIDTH   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [bsar_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsar_pkg::CMD_W-1:0]    command,
  input  logic [bsar_pkg::IDX_W-1:0]    process,
  input  logic [bsar_pkg::IDX_W-1:0]    resource,
  input  logic [bsar_pkg::AMT_W-1:0]    amount,
  input  logic                          final_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsar_pkg::STAT_W-1:0]   status,
  output logic [bsar_pkg::SEQ_W-1:0]    sequence_process,
  output logic                          last
);
  import bsar_pkg::*;

  localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int NW    = $clog2(MAX_PROCESSES + 1);
  localparam int RI    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CJ    = $clog2(MAX_RESOURCES + 1);
  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = COUNT_WIDTH;
  localparam int WW    = CW + PW + 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_REQ      = 10'b0000000010,
    S_GRANT    = 10'b0000000100,
    S_WINIT    = 10'b0000001000,
    S_SCAN_I   = 10'b0000010000,
    S_TEST     = 10'b0000100000,
    S_ADD      = 10'b0001000000,
    S_UNDO     = 10'b0010000000,
    S_EMIT_RD  = 10'b0100000000,
    S_EMIT_PUT = 10'b1000000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] num_processes, num_resources;
  logic [NW-1:0]    n_use;
  logic [CJ-1:0]    m_use;

  logic [PW-1:0]    p_reg;
  logic             is_req, flag_exc, flag_unav, flag_fail, found;
  logic [NW-1:0]    i_idx, count, k;
  logic [MAX_PROCESSES-1:0] finished;
  logic [CJ-1:0]    rj;
  logic             dv;
  logic [RI-1:0]    dj;
  logic [MAX_RESOURCES-1:0] req_set;

  // Memories and their registered read data.
  logic [CW-1:0] alloc_mem [DEPTH];
  logic [CW-1:0] max_mem   [DEPTH];
  logic [CW-1:0] avail_mem [MAX_RESOURCES];
  logic [WW-1:0] work_mem  [MAX_RESOURCES];
  logic [CW-1:0] req_mem   [MAX_RESOURCES];
  logic [PW-1:0] so_mem    [MAX_PROCESSES];

  logic [CW-1:0] a_rd, m_rd, v_rd, r_rd;
  logic [WW-1:0] w_rd;
  logic          r_vld;
  logic [PW-1:0] so_rd;

  logic          acc, phase_on, issue, last_j;
  logic [PW-1:0] row, prow;
  logic [RI-1:0] col, rcol;
  logic [AW-1:0] rd_addr, ph_addr, in_addr;
  logic [PW+3:0] px;
  logic [RI+3:0] rx;
  logic [CW+7:0] amt_x;
  logic [CW-1:0] amt, r_eff;
  logic          ok_p, ok_r, bad_p;
  logic          cur_exc, cur_unav, cur_fail, exc_any, unav_any, fail_any;
  logic          i_at_end, fin_i, count_done, k_last;
  logic [PW+3:0] sox;

  logic          a_we, m_we, v_we, w_we, r_we, so_we, req_clear;
  logic [AW-1:0] a_waddr;
  logic [CW-1:0] a_wdata, v_wdata;
  logic [WW-1:0] w_wdata;
  logic [RI-1:0] v_waddr, w_waddr;

  logic      out_load;
  out_word_t out_word, out_q;

  // Register values out of range act as the nearest legal count.
  always_comb begin
    if (num_processes == '0) begin
      n_use = NW'(1);
    end else if (32'(num_processes) > MAX_PROCESSES) begin
      n_use = NW'(MAX_PROCESSES);
    end else begin
      n_use = NW'(num_processes);
    end
    if (num_resources == '0) begin
      m_use = CJ'(1);
    end else if (32'(num_resources) > MAX_RESOURCES) begin
      m_use = CJ'(MAX_RESOURCES);
    end else begin
      m_use = CJ'(num_resources);
    end
  end

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  assign px    = {PW'(0), process};
  assign rx    = {RI'(0), resource};
  assign prow  = px[PW-1:0];
  assign rcol  = rx[RI-1:0];
  assign amt_x = {CW'(0), amount};
  assign amt   = amt_x[CW-1:0];
  assign ok_p  = 32'(process) < MAX_PROCESSES;
  assign ok_r  = 32'(resource) < MAX_RESOURCES;
  assign bad_p = 32'(process) >= 32'(n_use);

  assign in_addr = AW'(prow) * AW'(MAX_RESOURCES) + AW'(rcol);

  // Each walk issues one column read per cycle; its data comes back in the next cycle.
  assign phase_on = (state == S_REQ) || (state == S_GRANT) || (state == S_WINIT) ||
                    (state == S_TEST) || (state == S_ADD) || (state == S_UNDO);
  assign issue    = phase_on && (rj < m_use);
  assign col      = rj[RI-1:0];
  assign row      = ((state == S_TEST) || (state == S_ADD)) ? i_idx[PW-1:0] : p_reg;
  assign rd_addr  = AW'(row) * AW'(MAX_RESOURCES) + AW'(col);
  assign ph_addr  = AW'(row) * AW'(MAX_RESOURCES) + AW'(dj);
  assign last_j   = dv && ((CJ'(dj) + CJ'(1)) == m_use);

  assign r_eff    = r_vld ? r_rd : '0;
  assign cur_exc  = dv && (({1'b0, r_eff} + {1'b0, a_rd}) > {1'b0, m_rd});
  assign cur_unav = dv && (r_eff > v_rd);
  assign cur_fail = dv && ((WW+1)'(m_rd) > ((WW+1)'(w_rd) + (WW+1)'(a_rd)));
  assign exc_any  = flag_exc | cur_exc;
  assign unav_any = flag_unav | cur_unav;
  assign fail_any = flag_fail | cur_fail;

  assign i_at_end   = (i_idx == n_use);
  assign fin_i      = finished[i_idx[PW-1:0]];
  assign count_done = ((count + NW'(1)) == n_use);
  assign k_last     = ((k + NW'(1)) == n_use);

  assign sox = {4'b0, so_rd};

  // Memory write ports and the result word.
  always_comb begin
    a_we      = 1'b0;
    a_waddr   = in_addr;
    a_wdata   = amt;
    m_we      = 1'b0;
    v_we      = 1'b0;
    v_waddr   = rcol;
    v_wdata   = amt;
    w_we      = 1'b0;
    w_waddr   = dj;
    w_wdata   = WW'(v_rd);
    r_we      = 1'b0;
    so_we     = 1'b0;
    req_clear = 1'b0;
    out_load  = 1'b0;
    out_word  = '{status: ST_STORED, seq: '0, last: 1'b1};
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (command)
            CMD_WR_ALLOC: begin
              a_we     = ok_p && ok_r;
              out_load = 1'b1;
            end
            CMD_WR_MAX: begin
              m_we     = ok_p && ok_r;
              out_load = 1'b1;
            end
            CMD_WR_AVAIL: begin
              v_we     = ok_r;
              out_load = 1'b1;
            end
            CMD_REQUEST: begin
              r_we = ok_r;
              if (!final_element) begin
                out_load = 1'b1;
              end else if (bad_p) begin
                out_load        = 1'b1;
                out_word.status = ST_BAD_PROC;
                req_clear       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_REQ: begin
        if (last_j && (exc_any || unav_any)) begin
          out_load        = 1'b1;
          out_word.status = exc_any ? ST_EXCEEDS : ST_UNAVAIL;
          req_clear       = 1'b1;
        end
      end
      S_GRANT: begin
        a_we    = dv;
        a_waddr = ph_addr;
        a_wdata = a_rd + r_eff;
        v_we    = dv;
        v_waddr = dj;
        v_wdata = v_rd - r_eff;
      end
      S_WINIT: begin
        w_we = dv;
      end
      S_SCAN_I: begin
        if (i_at_end && !found && !is_req) begin
          out_load        = 1'b1;
          out_word.status = ST_UNSAFE;
        end
      end
      S_ADD: begin
        w_we    = dv;
        w_wdata = w_rd + WW'(a_rd);
        so_we   = last_j;
        req_clear = last_j && count_done && is_req;
      end
      S_UNDO: begin
        a_we    = dv;
        a_waddr = ph_addr;
        a_wdata = a_rd - r_eff;
        v_we    = dv;
        v_waddr = dj;
        v_wdata = v_rd + r_eff;
        if (last_j) begin
          out_load        = 1'b1;
          out_word.status = ST_UNSAFE;
          req_clear       = 1'b1;
        end
      end
      S_EMIT_PUT: begin
        out_load = 1'b1;
        out_word = '{status: ST_SAFE, seq: sox[3:0], last: k_last};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      alloc_mem[a_waddr] <= a_wdata;
    end
    a_rd <= alloc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      max_mem[in_addr] <= amt;
    end
    m_rd <= max_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      avail_mem[v_waddr] <= v_wdata;
    end
    v_rd <= avail_mem[col];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      work_mem[w_waddr] <= w_wdata;
    end
    w_rd <= work_mem[col];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      req_mem[rcol] <= amt;
    end
    r_rd  <= req_mem[col];
    r_vld <= req_set[col];
  end

  always_ff @(posedge clk) begin
    if (so_we) begin
      so_mem[count[PW-1:0]] <= i_idx[PW-1:0];
    end
    so_rd <= so_mem[k[PW-1:0]];
  end

  // Request elements never written since the last final element read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_set <= '0;
    end else if (req_clear) begin
      req_set <= '0;
    end else if (r_we) begin
      req_set[rcol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      num_processes <= CFG_W'(1);
      num_resources <= CFG_W'(1);
      rj            <= '0;
      dv            <= 1'b0;
      is_req        <= 1'b0;
      flag_exc      <= 1'b0;
      flag_unav     <= 1'b0;
      flag_fail     <= 1'b0;
      found         <= 1'b0;
      i_idx         <= '0;
      count         <= '0;
      k             <= '0;
      finished      <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_NUM_PROC) begin
          num_processes <= cfg_data;
        end else begin
          num_resources <= cfg_data;
        end
      end
      dv <= issue;
      if (issue) begin
        rj <= rj + CJ'(1);
      end
      case (state)
        S_IDLE: begin
          if (acc && (command == CMD_REQUEST) && final_element && !bad_p) begin
            p_reg     <= prow;
            is_req    <= 1'b1;
            flag_exc  <= 1'b0;
            flag_unav <= 1'b0;
            state     <= S_REQ;
          end else if (acc && (command == CMD_CHECK)) begin
            is_req <= 1'b0;
            state  <= S_WINIT;
          end
        end
        S_REQ: begin
          if (dv) begin
            flag_exc  <= exc_any;
            flag_unav <= unav_any;
          end
          if (last_j) begin
            rj    <= '0;
            dv    <= 1'b0;
            state <= (exc_any || unav_any) ? S_IDLE : S_GRANT;
          end
        end
        S_GRANT: begin
          if (last_j) begin
            rj    <= '0;
            dv    <= 1'b0;
            state <= S_WINIT;
          end
        end
        S_WINIT: begin
          if (last_j) begin
            rj       <= '0;
            dv       <= 1'b0;
            i_idx    <= '0;
            count    <= '0;
            found    <= 1'b0;
            finished <= '0;
            state    <= S_SCAN_I;
          end
        end
        S_SCAN_I: begin
          if (i_at_end) begin
            if (!found) begin
              state <= is_req ? S_UNDO : S_IDLE;
            end else begin
              found <= 1'b0;
              i_idx <= '0;
            end
          end else if (fin_i) begin
            i_idx <= i_idx + NW'(1);
          end else begin
            flag_fail <= 1'b0;
            state     <= S_TEST;
          end
        end
        S_TEST: begin
          if (dv) begin
            flag_fail <= fail_any;
          end
          if (last_j) begin
            rj <= '0;
            dv <= 1'b0;
            if (fail_any) begin
              i_idx <= i_idx + NW'(1);
              state <= S_SCAN_I;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          if (last_j) begin
            rj                       <= '0;
            dv                       <= 1'b0;
            finished[i_idx[PW-1:0]]  <= 1'b1;
            found                    <= 1'b1;
            count                    <= count + NW'(1);
            i_idx                    <= i_idx + NW'(1);
            if (count_done) begin
              k     <= '0;
              state <= S_EMIT_RD;
            end else begin
              state <= S_SCAN_I;
            end
          end
        end
        S_UNDO: begin
          if (last_j) begin
            rj    <= '0;
            dv    <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          // The order memory is read here; the word is loaded next cycle once
          // the output register is known to be free.
          if (!out_valid || out_ready) begin
            state <= S_EMIT_PUT;
          end
        end
        S_EMIT_PUT: begin
          k     <= k + NW'(1);
          state <= k_last ? S_IDLE : S_EMIT_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dj <= col;
  end

  bsar_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .word   (out_word),
    .valid  (out_valid),
    .ready  (out_ready),
    .word_q (out_q)
  );

  assign status           = out_q.status;
  assign sequence_process = out_q.seq;
  assign last             = out_q.last;

endmodule

`default_nettype wire
